// ===== hw/rtl/fau_pkg.sv =====
// Shared types, constants and helpers for the feature accumulator update block.
// Used by fau_ctrl, fau_datapath and feature_accumulator_update; depends on nothing.
`default_nettype none

package fau_pkg;

  // Field widths of the input and result words
  localparam int OP_W      = 3;
  localparam int FEATURE_W = 10;
  localparam int ELEMENT_W = 8;
  localparam int BUCKET_W  = 3;
  localparam int VALUE_W   = 32;

  // Storage widths
  localparam int ACC_W  = 16;
  localparam int BACC_W = 32;

  // Weight and accumulator rows are LANES elements wide
  localparam int LANES  = 16;
  localparam int LANE_W = 4;

  // Default sizes
  localparam int HALF_DIM_DEF = 256;
  localparam int BUCKETS_DEF  = 8;
  localparam int FEATURES_DEF = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_WR_WEIGHT  = 3'd0,
    OP_WR_BWEIGHT = 3'd1,
    OP_WR_ACC     = 3'd2,
    OP_WR_BACC    = 3'd3,
    OP_SUB        = 3'd4,
    OP_ADD        = 3'd5,
    OP_RD_ACC     = 3'd6,
    OP_RD_BACC    = 3'd7
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // load the accepted word
    logic wr_item;   // perform a single-word write
    logic rd_issue;  // read the addressed accumulator or bucket entry
    logic out_load;  // move the read result into the output register
    logic col_rd;    // read one column row during an add or subtract
    logic bkt_rd;    // read one bucket entry during an add or subtract
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic feat_ok;
    logic slot_free;
  } sts_t;

  // Index width for a store of n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fau_ctrl.sv =====
// Controller state machine of the feature accumulator update block.
// Sequences single writes, reads and column sweeps; depends on fau_pkg.
`default_nettype none

module fau_ctrl #(
  parameter int HALF_DIM = fau_pkg::HALF_DIM_DEF,
  parameter int BUCKETS  = fau_pkg::BUCKETS_DEF,
  parameter int IDX_W    = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fau_pkg::sts_t  sts,
  output fau_pkg::cmd_t       cmd,
  output logic [IDX_W-1:0]    idx
);

  localparam int ROWS = (HALF_DIM + fau_pkg::LANES - 1) / fau_pkg::LANES;
  localparam logic [IDX_W-1:0] ROW_LAST = IDX_W'(ROWS - 1);
  localparam logic [IDX_W-1:0] BKT_LAST = IDX_W'(BUCKETS - 1);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_LOAD     = 5'b00100,
    S_COL      = 5'b01000,
    S_BKT      = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx_next;

  // Hold state and sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Decide next step and issue commands
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_next = '0;
        unique case (sts.op) inside
          fau_pkg::OP_WR_WEIGHT, fau_pkg::OP_WR_BWEIGHT,
          fau_pkg::OP_WR_ACC, fau_pkg::OP_WR_BACC: begin
            cmd.wr_item = 1'b1;
            state_next  = S_IDLE;
          end
          fau_pkg::OP_RD_ACC, fau_pkg::OP_RD_BACC: begin
            cmd.rd_issue = 1'b1;
            state_next   = S_LOAD;
          end
          fau_pkg::OP_SUB, fau_pkg::OP_ADD: begin
            // drop an out-of-range feature without touching state
            state_next = sts.feat_ok ? S_COL : S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LOAD: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_COL: begin
        cmd.col_rd = 1'b1;
        if (idx == ROW_LAST) begin
          idx_next   = '0;
          state_next = S_BKT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_BKT: begin
        cmd.bkt_rd = 1'b1;
        if (idx == BKT_LAST) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fau_datapath.sv =====
// Datapath of the feature accumulator update block: word register, weight and
// accumulator memories, lane adders and output register. Depends on fau_pkg.
`default_nettype none

module fau_datapath #(
  parameter int HALF_DIM = fau_pkg::HALF_DIM_DEF,
  parameter int BUCKETS  = fau_pkg::BUCKETS_DEF,
  parameter int FEATURES = fau_pkg::FEATURES_DEF,
  parameter int IDX_W    = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fau_pkg::cmd_t                       cmd,
  input  wire logic [IDX_W-1:0]                    idx,
  output fau_pkg::sts_t                            sts,
  input  wire logic [fau_pkg::OP_W-1:0]            op,
  input  wire logic [fau_pkg::FEATURE_W-1:0]       feature,
  input  wire logic [fau_pkg::ELEMENT_W-1:0]       element,
  input  wire logic [fau_pkg::BUCKET_W-1:0]        bucket,
  input  wire logic signed [fau_pkg::VALUE_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [fau_pkg::VALUE_W-1:0]       read_value
);

  localparam int LANES   = fau_pkg::LANES;
  localparam int LANE_W  = fau_pkg::LANE_W;
  localparam int ACC_W   = fau_pkg::ACC_W;
  localparam int BACC_W  = fau_pkg::BACC_W;
  localparam int ROWS    = (HALF_DIM + LANES - 1) / LANES;
  localparam int ROW_W   = fau_pkg::idx_w(ROWS);
  localparam int BK_W    = fau_pkg::idx_w(BUCKETS);
  localparam int FEAT_W  = fau_pkg::idx_w(FEATURES);
  localparam int WM_DEPTH = FEATURES * (2 ** ROW_W);
  localparam int BW_DEPTH = FEATURES * (2 ** BK_W);

  typedef logic [LANES-1:0][ACC_W-1:0] row_t;

  // Memories
  row_t              wmem     [WM_DEPTH];
  logic [BACC_W-1:0] bwmem    [BW_DEPTH];
  row_t              acc_mem  [ROWS];
  logic [BACC_W-1:0] bacc_mem [BUCKETS];
  logic [ROWS-1:0]    acc_vld;
  logic [BUCKETS-1:0] bacc_vld;

  // Accepted word
  fau_pkg::op_t                  op_q;
  logic [fau_pkg::FEATURE_W-1:0] feat_q;
  logic [fau_pkg::ELEMENT_W-1:0] elem_q;
  logic [fau_pkg::BUCKET_W-1:0]  bkt_q;
  logic [fau_pkg::VALUE_W-1:0]   val_q;

  // Registered read data
  row_t              w_rd_q;
  row_t              acc_rd_q;
  logic              acc_rd_vld_q;
  logic [BACC_W-1:0] bw_rd_q;
  logic [BACC_W-1:0] bacc_rd_q;
  logic              bacc_rd_vld_q;

  // Write-back pipeline of a sweep
  logic             acc_pend, bkt_pend;
  logic [ROW_W-1:0] wb_row_q;
  logic [BK_W-1:0]  wb_bkt_q;

  logic              feat_ok, elem_ok, bkt_ok, is_add;
  logic [FEAT_W-1:0] feat_idx;
  logic [ROW_W-1:0]  elem_row, acc_raddr;
  logic [LANE_W-1:0] elem_lane;
  logic [BK_W-1:0]   bkt_idx, bacc_raddr;
  row_t              acc_base, acc_sum;
  logic [BACC_W-1:0] bacc_base, bacc_sum;
  logic [ACC_W-1:0]  acc_pick;
  logic [BACC_W-1:0] rd_result;

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= fau_pkg::op_t'(op);
      feat_q <= feature;
      elem_q <= element;
      bkt_q  <= bucket;
      val_q  <= value;
    end
  end

  // Decode indexes and range checks
  always_comb begin
    feat_ok   = 32'(feat_q) < FEATURES;
    elem_ok   = 32'(elem_q) < HALF_DIM;
    bkt_ok    = 32'(bkt_q) < BUCKETS;
    is_add    = (op_q == fau_pkg::OP_ADD);
    feat_idx  = FEAT_W'(feat_q);
    elem_row  = ROW_W'(elem_q >> LANE_W);
    elem_lane = elem_q[LANE_W-1:0];
    bkt_idx   = BK_W'(bkt_q);
    acc_raddr  = cmd.col_rd ? idx[ROW_W-1:0] : elem_row;
    bacc_raddr = cmd.bkt_rd ? idx[BK_W-1:0] : bkt_idx;
  end

  assign sts.op        = op_q;
  assign sts.feat_ok   = feat_ok;
  assign sts.slot_free = !out_valid || out_ready;

  // Weight memories: single-word writes, row reads during a sweep
  always_ff @(posedge clk) begin
    if (cmd.wr_item && op_q == fau_pkg::OP_WR_WEIGHT && feat_ok && elem_ok) begin
      wmem[{feat_idx, elem_row}][elem_lane] <= val_q[ACC_W-1:0];
    end
    if (cmd.wr_item && op_q == fau_pkg::OP_WR_BWEIGHT && feat_ok && bkt_ok) begin
      bwmem[{feat_idx, bkt_idx}] <= val_q;
    end
    if (cmd.col_rd) begin
      w_rd_q <= wmem[{feat_idx, idx[ROW_W-1:0]}];
    end
    if (cmd.bkt_rd) begin
      bw_rd_q <= bwmem[{feat_idx, idx[BK_W-1:0]}];
    end
  end

  // Add or subtract one row of lanes and one bucket entry
  always_comb begin
    acc_base  = acc_rd_vld_q ? acc_rd_q : '0;
    bacc_base = bacc_rd_vld_q ? bacc_rd_q : '0;
    for (int l = 0; l < LANES; l++) begin
      acc_sum[l] = is_add ? acc_base[l] + w_rd_q[l] : acc_base[l] - w_rd_q[l];
    end
    bacc_sum = is_add ? bacc_base + bw_rd_q : bacc_base - bw_rd_q;
  end

  // Track pending write-backs
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
      bkt_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.col_rd;
      bkt_pend <= cmd.bkt_rd;
    end
    wb_row_q <= idx[ROW_W-1:0];
    wb_bkt_q <= idx[BK_W-1:0];
  end

  // Accumulator memories: write-back, single-element writes, registered reads
  always_ff @(posedge clk) begin
    if (acc_pend) begin
      acc_mem[wb_row_q] <= acc_sum;
    end else if (cmd.wr_item && op_q == fau_pkg::OP_WR_ACC && elem_ok) begin
      // zero the rest of a row never written before
      for (int l = 0; l < LANES; l++) begin
        if (LANE_W'(l) == elem_lane) begin
          acc_mem[elem_row][l] <= val_q[ACC_W-1:0];
        end else if (!acc_vld[elem_row]) begin
          acc_mem[elem_row][l] <= '0;
        end
      end
    end
    if (bkt_pend) begin
      bacc_mem[wb_bkt_q] <= bacc_sum;
    end else if (cmd.wr_item && op_q == fau_pkg::OP_WR_BACC && bkt_ok) begin
      bacc_mem[bkt_idx] <= val_q;
    end
    if (cmd.col_rd || cmd.rd_issue) begin
      acc_rd_q     <= acc_mem[acc_raddr];
      acc_rd_vld_q <= acc_vld[acc_raddr];
    end
    if (cmd.bkt_rd || cmd.rd_issue) begin
      bacc_rd_q     <= bacc_mem[bacc_raddr];
      bacc_rd_vld_q <= bacc_vld[bacc_raddr];
    end
  end

  // Valid bits: an entry not yet written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld  <= '0;
      bacc_vld <= '0;
    end else begin
      if (acc_pend) begin
        acc_vld[wb_row_q] <= 1'b1;
      end else if (cmd.wr_item && op_q == fau_pkg::OP_WR_ACC && elem_ok) begin
        acc_vld[elem_row] <= 1'b1;
      end
      if (bkt_pend) begin
        bacc_vld[wb_bkt_q] <= 1'b1;
      end else if (cmd.wr_item && op_q == fau_pkg::OP_WR_BACC && bkt_ok) begin
        bacc_vld[bkt_idx] <= 1'b1;
      end
    end
  end

  // Select and extend the read result
  always_comb begin
    acc_pick = acc_base[elem_lane];
    if (op_q == fau_pkg::OP_RD_ACC) begin
      rd_result = elem_ok ? {{(BACC_W-ACC_W){acc_pick[ACC_W-1]}}, acc_pick} : '0;
    end else begin
      rd_result = bkt_ok ? bacc_base : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      read_value <= rd_result;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/feature_accumulator_update.sv =====
// A write goes from accept through dispatch straight back to idle. A read issues its
// memory read in dispatch, then loads its result word into the output register once the
// output slot is free. Add/subtract sweeps ROWS = ceil(HALF_DIM / 16) rows, then BUCKETS:
// one 16-word weight row per cycle through the weight memory read port, then one bucket.
// Reset clears the controller, output valid and the accumulator valid bits, so both
// accumulators read as zero; weight memories are not cleared. Depends on fau_pkg.
`default_nettype none

module feature_accumulator_update #(
  parameter int HALF_DIM = fau_pkg::HALF_DIM_DEF,
  parameter int BUCKETS  = fau_pkg::BUCKETS_DEF,
  parameter int FEATURES = fau_pkg::FEATURES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [fau_pkg::OP_W-1:0]            op,
  input  wire logic [fau_pkg::FEATURE_W-1:0]       feature,
  input  wire logic [fau_pkg::ELEMENT_W-1:0]       element,
  input  wire logic [fau_pkg::BUCKET_W-1:0]        bucket,
  input  wire logic signed [fau_pkg::VALUE_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [fau_pkg::VALUE_W-1:0]       read_value
);

  localparam int ROWS  = (HALF_DIM + fau_pkg::LANES - 1) / fau_pkg::LANES;
  localparam int ROW_W = fau_pkg::idx_w(ROWS);
  localparam int BK_W  = fau_pkg::idx_w(BUCKETS);
  localparam int IDX_W = (ROW_W > BK_W) ? ROW_W : BK_W;

  fau_pkg::cmd_t    cmd;
  fau_pkg::sts_t    sts;
  logic [IDX_W-1:0] idx;

  // Sequence each word
  fau_ctrl #(
    .HALF_DIM (HALF_DIM),
    .BUCKETS  (BUCKETS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  // Store, accumulate and read back
  fau_datapath #(
    .HALF_DIM (HALF_DIM),
    .BUCKETS  (BUCKETS),
    .FEATURES (FEATURES),
    .IDX_W    (IDX_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .idx        (idx),
    .sts        (sts),
    .op         (op),
    .feature    (feature),
    .element    (element),
    .bucket     (bucket),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value)
  );

endmodule

`default_nettype wire
